// ===== rtl/rau_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rau_pkg
// Shared widths, defaults and operation codes for the rational arithmetic unit.
// ---------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int NUM_W             = 32;
    localparam int DEN_W             = 30;
    localparam int FUNC_W            = 4;

    localparam logic [FUNC_W-1:0] FN_ADD = 4'd0;
    localparam logic [FUNC_W-1:0] FN_SUB = 4'd1;
    localparam logic [FUNC_W-1:0] FN_MUL = 4'd2;
    localparam logic [FUNC_W-1:0] FN_DIV = 4'd3;
    localparam logic [FUNC_W-1:0] FN_INC = 4'd4;
    localparam logic [FUNC_W-1:0] FN_DEC = 4'd5;
    localparam logic [FUNC_W-1:0] FN_EQ  = 4'd6;
    localparam logic [FUNC_W-1:0] FN_NE  = 4'd7;
    localparam logic [FUNC_W-1:0] FN_LT  = 4'd8;
    localparam logic [FUNC_W-1:0] FN_LE  = 4'd9;
    localparam logic [FUNC_W-1:0] FN_GT  = 4'd10;
    localparam logic [FUNC_W-1:0] FN_GE  = 4'd11;

endpackage

// ===== rtl/rational_arith_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rational_arith_unit
// Arithmetic and comparison on two fractions with gcd reduction.
// ---------------------------------------------------------------------------
// Input channel i_valid/o_ready carries one beat: an operation code and two
// fractions (signed numerator, positive denominator; a zero denominator is
// taken as 1). Output channel o_valid/i_ready carries one beat per input:
// result numerator, result denominator and a comparison flag.
// One beat is worked on at a time; o_ready is high only while idle.
// Steps: the cross products and the numerator and denominator products
// go through the shared multiplier, then the raw result is formed, then
// for add/sub/mul/div a binary gcd loop runs, one step a cycle, and two
// restoring divisions by the gcd run one after the other through one
// shared divider. Increment, decrement and comparisons skip gcd and
// division and go from the raw result straight to the output register.
// The result is held in the output register until i_ready takes it; the
// block accepts no new beat meanwhile. Reset returns the sequencer to idle
// and drops any beat in flight.
// ---------------------------------------------------------------------------
module rational_arith_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [rau_pkg::FUNC_W-1:0]            i_func,
    input  logic signed [OPERAND_WIDTH-1:0]       i_a_num,
    input  logic [OPERAND_WIDTH-2:0]              i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]       i_b_num,
    input  logic [OPERAND_WIDTH-2:0]              i_b_den,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [rau_pkg::NUM_W-1:0]      o_res_num,
    output logic [rau_pkg::DEN_W-1:0]             o_res_den,
    output logic                                  o_flag
);

    localparam int W   = OPERAND_WIDTH;
    localparam int MW  = 2 * W;
    localparam int NW  = 2 * W + 1;
    localparam int XW  = (NW > rau_pkg::NUM_W) ? NW : rau_pkg::NUM_W;
    localparam int DXW = (MW > rau_pkg::DEN_W) ? MW : rau_pkg::DEN_W;
    localparam int KW  = $clog2(MW + 1);
    localparam int CW  = $clog2(MW + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_FORM = 6'b000100,
        S_GCD  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state                      r_state, n_state;
    logic [rau_pkg::FUNC_W-1:0]  r_func;
    logic signed [W-1:0]         r_an, r_bn;
    logic [W-2:0]                r_ad, r_bd;
    logic [1:0]                  r_step, n_step;
    logic signed [MW-1:0]        r_lhs, n_lhs, r_rhs, n_rhs, r_nprod, n_nprod;
    logic [MW-1:0]               r_dprod, n_dprod;
    logic                        r_neg, n_neg;
    logic [MW-1:0]               r_x, n_x, r_y, n_y, r_mag, n_mag, r_den, n_den;
    logic [MW-1:0]               r_g, n_g, r_q, n_q, r_rem, n_rem, r_qn, n_qn;
    logic [KW-1:0]               r_k, n_k;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic                        r_phase, n_phase;
    logic signed [rau_pkg::NUM_W-1:0] r_onum, n_onum;
    logic [rau_pkg::DEN_W-1:0]   r_oden, n_oden;
    logic                        r_flag, n_flag;

    logic signed [W:0]           w_ma, w_mb, w_bmag;
    logic signed [2*W+1:0]       w_prod;
    logic signed [NW-1:0]        w_n, w_fn;
    logic [MW-1:0]               w_d, w_nmag;
    logic signed [XW-1:0]        w_nx, w_fx;
    logic [DXW-1:0]              w_dx, w_qx;
    logic [MW:0]                 w_tr, w_sub;
    logic                        w_qbit;
    logic [MW-1:0]               w_qnew, w_rnew;

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = (r_state == S_OUT);
    assign o_res_num = r_onum;
    assign o_res_den = r_oden;
    assign o_flag    = r_flag;

    assign w_bmag = r_bn[W-1] ? -{r_bn[W-1], r_bn} : {r_bn[W-1], r_bn};

    always_comb begin
        case (r_step)
            2'd0: begin
                w_ma = {r_an[W-1], r_an};
                w_mb = signed'({2'b00, r_bd});
            end
            2'd1: begin
                w_ma = {r_bn[W-1], r_bn};
                w_mb = signed'({2'b00, r_ad});
            end
            2'd2: begin
                w_ma = {r_an[W-1], r_an};
                w_mb = {r_bn[W-1], r_bn};
            end
            default: begin
                w_ma = signed'({2'b00, r_ad});
                w_mb = (r_func == rau_pkg::FN_DIV) ? w_bmag : signed'({2'b00, r_bd});
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    assign w_sub  = w_tr - {1'b0, r_g};
    assign w_tr   = {r_rem, r_q[MW-1]};
    assign w_qbit = !w_sub[MW];
    assign w_rnew = w_qbit ? w_sub[MW-1:0] : w_tr[MW-1:0];
    assign w_qnew = {r_q[MW-2:0], w_qbit};
    assign w_fn   = r_neg ? -signed'({1'b0, r_qn}) : signed'({1'b0, r_qn});
    assign w_fx   = XW'(w_fn);
    assign w_qx   = DXW'(w_qnew);

    always_comb begin
        case (r_func)
            rau_pkg::FN_ADD: w_n = NW'(r_lhs) + NW'(r_rhs);
            rau_pkg::FN_SUB: w_n = NW'(r_lhs) - NW'(r_rhs);
            rau_pkg::FN_MUL: w_n = NW'(r_nprod);
            rau_pkg::FN_DIV: w_n = r_bn[W-1] ? -NW'(r_lhs) : NW'(r_lhs);
            rau_pkg::FN_INC: w_n = NW'(r_an) + NW'(signed'({1'b0, r_ad}));
            rau_pkg::FN_DEC: w_n = NW'(r_an) - NW'(signed'({1'b0, r_ad}));
            default:         w_n = '0;
        endcase
        w_d    = (r_dprod == '0) ? MW'(1) : r_dprod;
        w_nmag = w_n[NW-1] ? MW'(-w_n) : MW'(w_n);
        w_nx   = XW'(w_n);
        w_dx   = DXW'(r_ad);
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_lhs   = r_lhs;
        n_rhs   = r_rhs;
        n_nprod = r_nprod;
        n_dprod = r_dprod;
        n_neg   = r_neg;
        n_x     = r_x;
        n_y     = r_y;
        n_mag   = r_mag;
        n_den   = r_den;
        n_g     = r_g;
        n_q     = r_q;
        n_rem   = r_rem;
        n_qn    = r_qn;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        n_onum  = r_onum;
        n_oden  = r_oden;
        n_flag  = r_flag;
        case (r_state)
            S_IDLE: begin
                n_step = 2'd0;
                if (i_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                case (r_step)
                    2'd0:    n_lhs   = w_prod[MW-1:0];
                    2'd1:    n_rhs   = w_prod[MW-1:0];
                    2'd2:    n_nprod = w_prod[MW-1:0];
                    default: n_dprod = w_prod[MW-1:0];
                endcase
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_state = S_FORM;
                end
            end
            S_FORM: begin
                n_flag = 1'b0;
                n_onum = '0;
                n_oden = rau_pkg::DEN_W'(1);
                n_state = S_OUT;
                case (r_func)
                    rau_pkg::FN_ADD, rau_pkg::FN_SUB, rau_pkg::FN_MUL, rau_pkg::FN_DIV: begin
                        n_neg   = w_n[NW-1];
                        n_x     = w_nmag;
                        n_mag   = w_nmag;
                        n_y     = w_d;
                        n_den   = w_d;
                        n_k     = '0;
                        n_state = S_GCD;
                    end
                    rau_pkg::FN_INC, rau_pkg::FN_DEC: begin
                        n_onum = w_nx[rau_pkg::NUM_W-1:0];
                        n_oden = w_dx[rau_pkg::DEN_W-1:0];
                    end
                    rau_pkg::FN_EQ: n_flag = (r_lhs == r_rhs);
                    rau_pkg::FN_NE: n_flag = (r_lhs != r_rhs);
                    rau_pkg::FN_LT: n_flag = (r_lhs <  r_rhs);
                    rau_pkg::FN_LE: n_flag = (r_lhs <= r_rhs);
                    rau_pkg::FN_GT: n_flag = (r_lhs >  r_rhs);
                    rau_pkg::FN_GE: n_flag = (r_lhs >= r_rhs);
                    default:        n_flag = 1'b0;
                endcase
            end
            S_GCD: begin
                if (r_x == '0) begin
                    n_g     = r_y << r_k;
                    n_q     = r_mag;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_phase = 1'b0;
                    n_state = S_DIV;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + KW'(1);
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (r_x >= r_y) begin
                    n_x = (r_x - r_y) >> 1;
                end else begin
                    n_y = (r_y - r_x) >> 1;
                end
            end
            S_DIV: begin
                n_q   = w_qnew;
                n_rem = w_rnew;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(MW - 1)) begin
                    if (!r_phase) begin
                        n_qn    = w_qnew;
                        n_q     = r_den;
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_phase = 1'b1;
                    end else begin
                        n_onum  = w_fx[rau_pkg::NUM_W-1:0];
                        n_oden  = w_qx[rau_pkg::DEN_W-1:0];
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_func <= i_func;
            r_an   <= i_a_num;
            r_bn   <= i_b_num;
            r_ad   <= (i_a_den == '0) ? (W-1)'(1) : i_a_den;
            r_bd   <= (i_b_den == '0) ? (W-1)'(1) : i_b_den;
        end
        r_step  <= n_step;
        r_lhs   <= n_lhs;
        r_rhs   <= n_rhs;
        r_nprod <= n_nprod;
        r_dprod <= n_dprod;
        r_neg   <= n_neg;
        r_x     <= n_x;
        r_y     <= n_y;
        r_mag   <= n_mag;
        r_den   <= n_den;
        r_g     <= n_g;
        r_q     <= n_q;
        r_rem   <= n_rem;
        r_qn    <= n_qn;
        r_k     <= n_k;
        r_cnt   <= n_cnt;
        r_phase <= n_phase;
        r_onum  <= n_onum;
        r_oden  <= n_oden;
        r_flag  <= n_flag;
    end

endmodule

// ===== verif/rational_arith_unit_check.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rational_arith_unit_check
// Watches both channels of the rational arithmetic unit, computes the
// expected fraction and flag for each accepted operand beat, and compares
// each result beat against the oldest pending expectation.
// ---------------------------------------------------------------------------
module rational_arith_unit_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_ready,
    input  logic [rau_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [15:0]                i_a_num,
    input  logic [14:0]                       i_a_den,
    input  logic signed [15:0]                i_b_num,
    input  logic [14:0]                       i_b_den,
    input  logic                              o_valid,
    input  logic                              i_ready,
    input  logic signed [rau_pkg::NUM_W-1:0]  o_res_num,
    input  logic [rau_pkg::DEN_W-1:0]         o_res_den,
    input  logic                              o_flag,
    output int                                o_err_cnt,
    output int                                o_pending,
    output int                                o_beats_in,
    output int                                o_beats_out
);

    typedef struct packed {
        logic signed [rau_pkg::NUM_W-1:0] num;
        logic [rau_pkg::DEN_W-1:0]        den;
        logic                             flag;
    } t_frac_res;

    t_frac_res expected_q[$];

    function automatic void reduce(inout longint n, inout longint d);
        longint x, y, t, g;
        x = (n < 0) ? -n : n;
        y = d;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        g = (x == 0) ? 1 : x;
        n = n / g;
        d = d / g;
        if (n == 0) d = 1;
    endfunction

    function automatic t_frac_res compute_fraction(logic [rau_pkg::FUNC_W-1:0] fn,
            logic signed [15:0] an_in, logic [14:0] ad_in,
            logic signed [15:0] bn_in, logic [14:0] bd_in);
        longint an, ad, bn, bd, lhs, rhs, n, d, rn, rd, tn, td;
        logic fl;
        t_frac_res r;
        an = an_in; bn = bn_in;
        ad = (ad_in == 0) ? 1 : ad_in;
        bd = (bd_in == 0) ? 1 : bd_in;
        lhs = an * bd;
        rhs = bn * ad;
        n = 0; d = 1; fl = 1'b0;
        case (fn)
            rau_pkg::FN_ADD: begin n = lhs + rhs; d = ad * bd; end
            rau_pkg::FN_SUB: begin n = lhs - rhs; d = ad * bd; end
            rau_pkg::FN_MUL: begin n = an * bn; d = ad * bd; end
            rau_pkg::FN_DIV: begin
                n = (bn < 0) ? -lhs : lhs;
                d = ad * ((bn < 0) ? -bn : bn);
            end
            rau_pkg::FN_INC: begin n = an + ad; d = ad; end
            rau_pkg::FN_DEC: begin n = an - ad; d = ad; end
            default: begin
                rn = an; rd = ad; tn = bn; td = bd;
                reduce(rn, rd);
                reduce(tn, td);
                case (fn)
                    rau_pkg::FN_EQ: fl = (rn == tn) && (rd == td);
                    rau_pkg::FN_NE: fl = !((rn == tn) && (rd == td));
                    rau_pkg::FN_LT: fl = lhs < rhs;
                    rau_pkg::FN_LE: fl = lhs <= rhs;
                    rau_pkg::FN_GT: fl = lhs > rhs;
                    rau_pkg::FN_GE: fl = lhs >= rhs;
                    default: fl = 1'b0;
                endcase
            end
        endcase
        if (fn <= rau_pkg::FN_DIV) begin
            if (d == 0) d = 1;
            reduce(n, d);
        end
        r.num  = n[rau_pkg::NUM_W-1:0];
        r.den  = d[rau_pkg::DEN_W-1:0];
        r.flag = fl;
        return r;
    endfunction

    initial begin
        o_err_cnt = 0;
        o_pending = 0;
        o_beats_in = 0;
        o_beats_out = 0;
    end

    always @(posedge i_clk) begin
        t_frac_res exp_r;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_q.push_back(compute_fraction(i_func, i_a_num, i_a_den,
                                                      i_b_num, i_b_den));
                o_beats_in <= o_beats_in + 1;
            end
            if (o_valid && i_ready) begin
                o_beats_out <= o_beats_out + 1;
                if (expected_q.size() == 0) begin
                    if (o_err_cnt < 10)
                        $display("%0t: result beat with nothing pending", $time);
                    o_err_cnt <= o_err_cnt + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.num !== o_res_num || exp_r.den !== o_res_den ||
                        exp_r.flag !== o_flag) begin
                        if (o_err_cnt < 10)
                            $display("%0t: mismatch exp %0d/%0d f%0b got %0d/%0d f%0b",
                                     $time, exp_r.num, exp_r.den, exp_r.flag,
                                     o_res_num, o_res_den, o_flag);
                        o_err_cnt <= o_err_cnt + 1;
                    end
                end
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

// ===== verif/rational_arith_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rational_arith_unit_test
// Drives directed and random operand beats into the rational arithmetic unit
// with random gaps and output stalls, including one long output stall, and
// reports the verdict from the checker's error count and pending count.
// ---------------------------------------------------------------------------
module rational_arith_unit_test;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_ready;
    logic [rau_pkg::FUNC_W-1:0]       i_func;
    logic signed [15:0]               i_a_num;
    logic [14:0]                      i_a_den;
    logic signed [15:0]               i_b_num;
    logic [14:0]                      i_b_den;
    logic                             o_valid;
    logic                             i_ready;
    logic signed [rau_pkg::NUM_W-1:0] o_res_num;
    logic [rau_pkg::DEN_W-1:0]        o_res_den;
    logic                             o_flag;
    int                               err_cnt;
    int                               pending;
    int                               beats_in;
    int                               beats_out;
    bit                               hold_off_req;

    rational_arith_unit #(.OPERAND_WIDTH(16)) i_dut (.*);

    rational_arith_unit_check i_check (
        .*,
        .o_err_cnt  (err_cnt),
        .o_pending  (pending),
        .o_beats_in (beats_in),
        .o_beats_out(beats_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic signed [15:0] pick_num();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sd0;
            3: return $signed(16'($urandom_range(0, 20))) - 16'sd10;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] pick_den();
        case ($urandom_range(0, 7))
            0: return 15'h7fff;
            1: return 15'd0;
            2: return 15'd1;
            3: return 15'($urandom_range(1, 12));
            default: return 15'($urandom);
        endcase
    endfunction

    task automatic send_beat(logic [rau_pkg::FUNC_W-1:0] fn, logic signed [15:0] an,
                             logic [14:0] ad, logic signed [15:0] bn,
                             logic [14:0] bd, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= fn;
        i_a_num <= an;
        i_a_den <= ad;
        i_b_num <= bn;
        i_b_den <= bd;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        repeat (20) @(negedge i_clk);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_ready <= 1'b0;
                repeat (600) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else if (o_valid && !i_ready) begin
                stall = $urandom_range(0, 16);
                repeat (stall) @(negedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        int wait_cnt;
        logic [rau_pkg::FUNC_W-1:0] fn;
        hold_off_req = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func  = rau_pkg::FN_ADD;
        i_a_num = '0;
        i_a_den = 15'd1;
        i_b_num = '0;
        i_b_den = 15'd1;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int f = 0; f < 16; f++)
            send_beat(rau_pkg::FUNC_W'(f), 16'sh8000, 15'h7fff, 16'sh7fff, 15'd1, 0);
        send_beat(rau_pkg::FN_DIV, 16'sd3, 15'd4, 16'sd0, 15'd5, 0);
        send_beat(rau_pkg::FN_DIV, 16'sh7fff, 15'h7fff, -16'sd5, 15'd0, 1);
        send_beat(rau_pkg::FN_ADD, 16'sd1, 15'd2, -16'sd1, 15'd2, 0);
        send_beat(rau_pkg::FN_EQ, 16'sd2, 15'd4, 16'sd1, 15'd2, 0);
        send_beat(rau_pkg::FN_MUL, 16'sh8000, 15'd0, 16'sh8000, 15'd0, 0);
        send_beat(rau_pkg::FN_SUB, 16'sh8000, 15'h7fff, 16'sh7fff, 15'h7fff, 0);
        send_beat(rau_pkg::FN_LE, 16'sd3, 15'd6, 16'sd1, 15'd2, 0);

        for (int k = 0; k < 480; k++) begin
            if (k == 200) hold_off_req = 1'b1;
            fn = ($urandom_range(0, 19) == 0)
                 ? rau_pkg::FUNC_W'($urandom_range(12, 15))
                 : rau_pkg::FUNC_W'($urandom_range(0, 11));
            send_beat(fn, pick_num(), pick_den(), pick_num(), pick_den(),
                      ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
        end
        i_valid <= 1'b0;

        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 20000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (200) @(posedge i_clk);
        $display("Sent %0d operand beats over all 16 codes, received %0d result beats,",
                 beats_in, beats_out);
        $display("with random gaps, output stalls and one long output hold-off.");
        if (err_cnt == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
